/* hw/rtl/fwpid_pkg.sv */
// Shared constants, register codes and control types of the four-wheel PID drive.
package fwpid_pkg;

   localparam int WHEELS        = 4;
   localparam int MAX_WHEELS    = 8;
   localparam int WHEEL_BITS    = (WHEELS > 1) ? $clog2(WHEELS) : 1;
   localparam int COUNT_BITS    = 16;
   localparam int TARGET_BITS   = 24;
   localparam int GAIN_BITS     = 16;
   localparam int PWM_BITS      = 15;
   localparam int MASK_BITS     = 4;
   localparam int ACC_FRAC      = 12;
   localparam int ERR_BITS      = 26;
   localparam int ACC_BITS      = PWM_BITS + ACC_FRAC + 1;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [GAIN_BITS-1:0] GAIN_P_RESET      = 16'd12800;
   localparam logic [GAIN_BITS-1:0] GAIN_I_RESET      = 16'd9600;
   localparam logic [GAIN_BITS-1:0] GAIN_D_RESET      = 16'd2400;
   localparam logic [GAIN_BITS-1:0] SPEED_SCALE_RESET = 16'd256;
   localparam logic [PWM_BITS-1:0]  PWM_LIMIT_RESET   = 15'd1000;
   localparam logic [MASK_BITS-1:0] INVERT_MASK_RESET = 4'd10;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_SPEED_SCALE = 3'd3,
      CSR_PWM_LIMIT   = 3'd4,
      CSR_INVERT_MASK = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain_p;
      logic [GAIN_BITS-1:0] gain_i;
      logic [GAIN_BITS-1:0] gain_d;
      logic [GAIN_BITS-1:0] speed_scale;
      logic [PWM_BITS-1:0]  pwm_limit;
      logic [MASK_BITS-1:0] invert_mask;
   } cfg_type;

   typedef enum logic [1:0] {
      MUL_MEAS = 2'd0,
      MUL_P    = 2'd1,
      MUL_I    = 2'd2,
      MUL_D    = 2'd3
   } mul_op_type;

   typedef struct packed {
      logic                  load;
      logic [WHEEL_BITS-1:0] wheel;
      logic                  mul_en;
      mul_op_type            mul_op;
      logic                  err_en;
      logic                  sum_init;
      logic                  sum_add;
      logic                  update;
      logic                  publish;
   } cmd_type;

endpackage

/* hw/rtl/fwpid_if.sv */
// Handshake channel interfaces: tick item, drive result and register write.
interface fwpid_req_if #(
   parameter int COUNT_BITS = fwpid_pkg::COUNT_BITS
);
   logic                                      valid;
   logic                                      ready;
   logic signed [COUNT_BITS-1:0]              count_a;
   logic signed [COUNT_BITS-1:0]              count_b;
   logic signed [COUNT_BITS-1:0]              count_c;
   logic signed [COUNT_BITS-1:0]              count_d;
   logic signed [fwpid_pkg::TARGET_BITS-1:0]  target_a;
   logic signed [fwpid_pkg::TARGET_BITS-1:0]  target_b;
   logic signed [fwpid_pkg::TARGET_BITS-1:0]  target_c;
   logic signed [fwpid_pkg::TARGET_BITS-1:0]  target_d;

   modport source (
      output valid, count_a, count_b, count_c, count_d,
      output target_a, target_b, target_c, target_d,
      input  ready
   );
   modport sink (
      input  valid, count_a, count_b, count_c, count_d,
      input  target_a, target_b, target_c, target_d,
      output ready
   );
endinterface

interface fwpid_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fwpid_pkg::PWM_BITS-1:0]   fwd_a;
   logic [fwpid_pkg::PWM_BITS-1:0]   rev_a;
   logic [fwpid_pkg::PWM_BITS-1:0]   fwd_b;
   logic [fwpid_pkg::PWM_BITS-1:0]   rev_b;
   logic [fwpid_pkg::PWM_BITS-1:0]   fwd_c;
   logic [fwpid_pkg::PWM_BITS-1:0]   rev_c;
   logic [fwpid_pkg::PWM_BITS-1:0]   fwd_d;
   logic [fwpid_pkg::PWM_BITS-1:0]   rev_d;

   modport source (
      output valid, fwd_a, rev_a, fwd_b, rev_b, fwd_c, rev_c, fwd_d, rev_d,
      input  ready
   );
   modport sink (
      input  valid, fwd_a, rev_a, fwd_b, rev_b, fwd_c, rev_c, fwd_d, rev_d,
      output ready
   );
endinterface

interface fwpid_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [fwpid_pkg::CSR_ADDR_BITS-1:0]   index;
   logic [fwpid_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/fwpid_csr.sv */
// Configuration register file: gains, speed scale, PWM limit and invert mask.
module fwpid_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fwpid_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [fwpid_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output fwpid_pkg::cfg_type                   cfg
);

   fwpid_pkg::cfg_type cfg_ff;
   fwpid_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fwpid_pkg::CSR_GAIN_P:      cfg_in.gain_p      = csr_data;
            fwpid_pkg::CSR_GAIN_I:      cfg_in.gain_i      = csr_data;
            fwpid_pkg::CSR_GAIN_D:      cfg_in.gain_d      = csr_data;
            fwpid_pkg::CSR_SPEED_SCALE: cfg_in.speed_scale = csr_data;
            fwpid_pkg::CSR_PWM_LIMIT:
               cfg_in.pwm_limit = csr_data[fwpid_pkg::PWM_BITS-1:0];
            fwpid_pkg::CSR_INVERT_MASK:
               cfg_in.invert_mask = csr_data[fwpid_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p      <= fwpid_pkg::GAIN_P_RESET;
         cfg_ff.gain_i      <= fwpid_pkg::GAIN_I_RESET;
         cfg_ff.gain_d      <= fwpid_pkg::GAIN_D_RESET;
         cfg_ff.speed_scale <= fwpid_pkg::SPEED_SCALE_RESET;
         cfg_ff.pwm_limit   <= fwpid_pkg::PWM_LIMIT_RESET;
         cfg_ff.invert_mask <= fwpid_pkg::INVERT_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/fwpid_ctrl.sv */
// Sequencer: steps each wheel through measure, error, three products and update.
module fwpid_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fwpid_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MEAS = 8'b0000_0010,
      ST_ERR  = 8'b0000_0100,
      ST_MULP = 8'b0000_1000,
      ST_MULI = 8'b0001_0000,
      ST_MULD = 8'b0010_0000,
      ST_UPD  = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type                              state_ff;
   state_type                              state_in;
   logic [fwpid_pkg::WHEEL_BITS-1:0]       wheel_ff;
   logic [fwpid_pkg::WHEEL_BITS-1:0]       wheel_in;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic                                   last_wheel;
   logic                                   out_free;

   assign last_wheel = (wheel_ff == fwpid_pkg::WHEEL_BITS'(fwpid_pkg::WHEELS - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      wheel_in     = wheel_ff;
      cmd          = '0;
      cmd.wheel    = wheel_ff;
      cmd.mul_op   = fwpid_pkg::MUL_MEAS;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               wheel_in = '0;
               state_in = ST_MEAS;
            end
         end
         ST_MEAS: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = fwpid_pkg::MUL_MEAS;
            state_in   = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_MULP;
         end
         ST_MULP: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = fwpid_pkg::MUL_P;
            state_in   = ST_MULI;
         end
         ST_MULI: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_op   = fwpid_pkg::MUL_I;
            cmd.sum_init = 1'b1;
            state_in     = ST_MULD;
         end
         ST_MULD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_op  = fwpid_pkg::MUL_D;
            cmd.sum_add = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            if (last_wheel) begin
               state_in = ST_FIN;
            end else begin
               wheel_in = wheel_ff + fwpid_pkg::WHEEL_BITS'(1);
               state_in = ST_MEAS;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over an untaken beat");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_MEAS && wheel_ff == '0))
      else $error("item start did not begin at the first wheel");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_wheel) |=> (state_ff == ST_FIN))
      else $error("last wheel update did not lead to result stage");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result valid raised without a publish");
`endif

endmodule

/* hw/rtl/fwpid_dp.sv */
// Datapath: item and state registers, shared multiplier, accumulator clamp and PWM split.
module fwpid_dp #(
   parameter int COUNT_BITS = fwpid_pkg::COUNT_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fwpid_pkg::cmd_type                      cmd,
   input  fwpid_pkg::cfg_type                      cfg,
   input  logic signed [COUNT_BITS-1:0]            item_count  [fwpid_pkg::WHEELS],
   input  logic signed [fwpid_pkg::TARGET_BITS-1:0] item_target [fwpid_pkg::WHEELS],
   output logic [fwpid_pkg::PWM_BITS-1:0]          rsp_fwd     [fwpid_pkg::WHEELS],
   output logic [fwpid_pkg::PWM_BITS-1:0]          rsp_rev     [fwpid_pkg::WHEELS]
);

   localparam int TB         = fwpid_pkg::TARGET_BITS;
   localparam int EB         = fwpid_pkg::ERR_BITS;
   localparam int AB         = fwpid_pkg::ACC_BITS;
   localparam int PB         = fwpid_pkg::PWM_BITS;
   localparam int NW         = fwpid_pkg::WHEELS;
   localparam int GB         = fwpid_pkg::GAIN_BITS + 1;
   localparam int D1_BITS    = EB + 1;
   localparam int D2_BITS    = EB + 2;
   localparam int MUL_A_BITS = (COUNT_BITS > D2_BITS) ? COUNT_BITS : D2_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + GB;
   localparam int SUM_BITS   = PROD_BITS + 2;

   localparam logic signed [PROD_BITS-1:0] MEAS_MAX =
      PROD_BITS'((64'sd1 <<< (TB - 1)) - 64'sd1);
   localparam logic signed [PROD_BITS-1:0] MEAS_MIN = -MEAS_MAX - PROD_BITS'(1);

   logic signed [COUNT_BITS-1:0]   count_ff   [NW];
   logic signed [TB-1:0]           target_ff  [NW];
   logic signed [AB-1:0]           acc_ff     [NW];
   logic signed [EB-1:0]           e1_ff      [NW];
   logic signed [EB-1:0]           e2_ff      [NW];
   logic [PB-1:0]                  work_fwd_ff[NW];
   logic [PB-1:0]                  work_rev_ff[NW];
   logic [PB-1:0]                  rsp_fwd_ff [NW];
   logic [PB-1:0]                  rsp_rev_ff [NW];

   logic signed [PROD_BITS-1:0]    prod_ff;
   logic signed [PROD_BITS-1:0]    prod_in;
   logic signed [SUM_BITS-1:0]     sum_ff;
   logic signed [SUM_BITS-1:0]     sum_in;
   logic signed [EB-1:0]           err_ff;
   logic signed [D1_BITS-1:0]      d1_ff;
   logic signed [D2_BITS-1:0]      d2_ff;

   logic [fwpid_pkg::MAX_WHEELS-1:0] mask_wide;
   logic signed [TB-1:0]           meas_sat;
   logic signed [TB:0]             tgt;
   logic signed [EB-1:0]           err;
   logic signed [EB-1:0]           e1;
   logic signed [D1_BITS-1:0]      d1;
   logic signed [D2_BITS-1:0]      d2;
   logic signed [MUL_A_BITS-1:0]   mul_a;
   logic signed [GB-1:0]           mul_b;
   logic signed [SUM_BITS-1:0]     total;
   logic signed [SUM_BITS-1:0]     lim;
   logic signed [SUM_BITS-1:0]     clamped;
   logic signed [AB-1:0]           acc_new;
   logic signed [AB-1:0]           acc_mag;
   logic [PB-1:0]                  fwd_new;
   logic [PB-1:0]                  rev_new;

   assign mask_wide = {{(fwpid_pkg::MAX_WHEELS - fwpid_pkg::MASK_BITS){1'b0}},
                       cfg.invert_mask};

   always_comb begin
      if (prod_ff > MEAS_MAX) begin
         meas_sat = {1'b0, {(TB - 1){1'b1}}};
      end else if (prod_ff < MEAS_MIN) begin
         meas_sat = {1'b1, {(TB - 1){1'b0}}};
      end else begin
         meas_sat = prod_ff[TB-1:0];
      end
      tgt = (TB + 1)'(target_ff[cmd.wheel]);
      if (mask_wide[cmd.wheel]) begin
         tgt = -tgt;
      end
      err = EB'(tgt) - EB'(meas_sat);
      e1  = e1_ff[cmd.wheel];
      d1  = D1_BITS'(err) - D1_BITS'(e1);
      d2  = D2_BITS'(err) - (D2_BITS'(e1) <<< 1) + D2_BITS'(e2_ff[cmd.wheel]);
   end

   always_comb begin
      case (cmd.mul_op)
         fwpid_pkg::MUL_MEAS: begin
            mul_a = MUL_A_BITS'(count_ff[cmd.wheel]);
            mul_b = $signed({1'b0, cfg.speed_scale});
         end
         fwpid_pkg::MUL_P: begin
            mul_a = MUL_A_BITS'(d1_ff);
            mul_b = $signed({1'b0, cfg.gain_p});
         end
         fwpid_pkg::MUL_I: begin
            mul_a = MUL_A_BITS'(err_ff);
            mul_b = $signed({1'b0, cfg.gain_i});
         end
         fwpid_pkg::MUL_D: begin
            mul_a = MUL_A_BITS'(d2_ff);
            mul_b = $signed({1'b0, cfg.gain_d});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   always_comb begin
      if (cmd.sum_init) begin
         sum_in = SUM_BITS'(acc_ff[cmd.wheel]) + SUM_BITS'(prod_ff);
      end else begin
         sum_in = sum_ff + SUM_BITS'(prod_ff);
      end
   end

   always_comb begin
      total = sum_ff + SUM_BITS'(prod_ff);
      lim   = $signed(SUM_BITS'({cfg.pwm_limit, {fwpid_pkg::ACC_FRAC{1'b0}}}));
      if (total > lim) begin
         clamped = lim;
      end else if (total < -lim) begin
         clamped = -lim;
      end else begin
         clamped = total;
      end
      acc_new = AB'(clamped);
      acc_mag = -acc_new;
      if (acc_new > AB'(0)) begin
         fwd_new = acc_new[fwpid_pkg::ACC_FRAC +: PB];
         rev_new = '0;
      end else begin
         fwd_new = '0;
         rev_new = acc_mag[fwpid_pkg::ACC_FRAC +: PB];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff  <= item_count;
         target_ff <= item_target;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.sum_init || cmd.sum_add) begin
         sum_ff <= sum_in;
      end
      if (cmd.err_en) begin
         err_ff <= err;
         d1_ff  <= d1;
         d2_ff  <= d2;
      end
      if (cmd.update) begin
         work_fwd_ff[cmd.wheel] <= fwd_new;
         work_rev_ff[cmd.wheel] <= rev_new;
      end
      if (cmd.publish) begin
         rsp_fwd_ff <= work_fwd_ff;
         rsp_rev_ff <= work_rev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) begin
            acc_ff[i] <= '0;
            e1_ff[i]  <= '0;
            e2_ff[i]  <= '0;
         end
      end else if (cmd.update) begin
         acc_ff[cmd.wheel] <= acc_new;
         e2_ff[cmd.wheel]  <= e1_ff[cmd.wheel];
         e1_ff[cmd.wheel]  <= err_ff;
      end
   end

   assign rsp_fwd = rsp_fwd_ff;
   assign rsp_rev = rsp_rev_ff;

endmodule

/* hw/rtl/four_wheel_incremental_pid_drive.sv */
// Top level of the four-wheel incremental PID drive: channels, sequencer and datapath.
//
//   channel   direction  payload
//   req_ch    in         count_a..count_d, target_a..target_d (one control tick)
//   rsp_ch    out        fwd_a/rev_a .. fwd_d/rev_d PWM compare values
//   csr_ch    in         index, data (register write, always ready)
//
// Each item takes an accept step, then per wheel the steps through the single
// shared 28x17 multiplier (measure, error, P, I, D, update), then a publish step.
// Reset returns registers to defaults and clears accumulators and error history.
// A finished beat waits in the output register; the next item is accepted and
// computed meanwhile, then holds in the publish stage until that beat is taken.
module four_wheel_incremental_pid_drive #(
   parameter int COUNT_BITS = fwpid_pkg::COUNT_BITS
) (
   input  logic      clock,
   input  logic      reset,
   fwpid_req_if.sink   req_ch,
   fwpid_rsp_if.source rsp_ch,
   fwpid_csr_if.sink   csr_ch
);

   fwpid_pkg::cmd_type                        cmd;
   fwpid_pkg::cfg_type                        cfg;
   logic signed [COUNT_BITS-1:0]              item_count  [fwpid_pkg::WHEELS];
   logic signed [fwpid_pkg::TARGET_BITS-1:0]  item_target [fwpid_pkg::WHEELS];
   logic [fwpid_pkg::PWM_BITS-1:0]            rsp_fwd     [fwpid_pkg::WHEELS];
   logic [fwpid_pkg::PWM_BITS-1:0]            rsp_rev     [fwpid_pkg::WHEELS];

   assign item_count[0]  = COUNT_BITS'(req_ch.count_a);
   assign item_count[1]  = COUNT_BITS'(req_ch.count_b);
   assign item_count[2]  = COUNT_BITS'(req_ch.count_c);
   assign item_count[3]  = COUNT_BITS'(req_ch.count_d);
   assign item_target[0] = req_ch.target_a;
   assign item_target[1] = req_ch.target_b;
   assign item_target[2] = req_ch.target_c;
   assign item_target[3] = req_ch.target_d;

   assign rsp_ch.fwd_a = rsp_fwd[0];
   assign rsp_ch.rev_a = rsp_rev[0];
   assign rsp_ch.fwd_b = rsp_fwd[1];
   assign rsp_ch.rev_b = rsp_rev[1];
   assign rsp_ch.fwd_c = rsp_fwd[2];
   assign rsp_ch.rev_c = rsp_rev[2];
   assign rsp_ch.fwd_d = rsp_fwd[3];
   assign rsp_ch.rev_d = rsp_rev[3];

   fwpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   fwpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   fwpid_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .item_count  (item_count),
      .item_target (item_target),
      .rsp_fwd     (rsp_fwd),
      .rsp_rev     (rsp_rev)
   );

endmodule
